// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DOD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dod_pkg.sv -----
// Types, constants and helpers for the delay overuse detector.
`default_nettype none

package dod_pkg;

	localparam int OFFSET_W  = 20;
	localparam int GTD_W     = 18;
	localparam int COUNT_W   = 16;
	localparam int NOW_W     = 32;
	localparam int USAGE_W   = 2;
	localparam int THR_OUT_W = 18;
	localparam int THR_W     = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 18;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 42;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [THR_W-1:0] THR_MIN_Q16 = THR_W'(6 << 16);
	localparam logic [THR_W-1:0] THR_MAX_Q16 = THR_W'(600 << 16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_UP       = 3'd0,
		REG_GAIN_DOWN     = 3'd1,
		REG_OVERUSE_LIMIT = 3'd2,
		REG_INIT_THR      = 3'd3,
		REG_MAX_ADAPT     = 3'd4,
		REG_COUNT_CAP     = 3'd5,
		REG_MAX_STEP      = 3'd6
	} cfg_reg_t;

	typedef enum logic [USAGE_W-1:0] {
		USAGE_NORMAL = 2'd0,
		USAGE_OVER   = 2'd1,
		USAGE_UNDER  = 2'd2
	} usage_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MUL_T  = 7'b0000010,
		ST_CMP    = 7'b0000100,
		ST_MUL_K  = 7'b0001000,
		ST_MUL_DT = 7'b0010000,
		ST_UPD    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} seq_state_t;

	// Clamp a signed Q16 threshold candidate to 6..600 ms.
	function automatic logic [THR_W-1:0] thr_clamp(input logic signed [39:0] v);
		logic [THR_W-1:0] r;
		if (v < $signed({14'd0, THR_MIN_Q16}))
			r = THR_MIN_Q16;
		else if (v > $signed({14'd0, THR_MAX_Q16}))
			r = THR_MAX_Q16;
		else
			r = v[THR_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/delay_overuse_detector.sv -----
// Delay overuse detector: adaptive threshold and overuse state, one shared multiplier.
// On the full path the item passes MUL_T, CMP, MUL_K, MUL_DT, UPD and DONE; CMP goes to
// DONE when adaptation is frozen, MUL_T when delta_count < 2. The result is registered
// out of DONE, which an output stall holds; s_tready is high only in the idle state, so
// no new item is taken while one is in work. Reset (arst_n low) loads register defaults,
// sets the threshold to the clamped initial value and clears all detector state.
`default_nettype none

`include "assert_macros.svh"

module delay_overuse_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// offset_est[19:0], group_time_delta[37:20], delta_count[53:38], now_ms[85:54], zero
	input  wire logic [dod_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// usage_state[1:0], threshold_now[19:2], zero
	output logic      [dod_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [dod_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dod_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import dod_pkg::*;

	// configuration
	logic [15:0] gain_up_q, gain_down_q;
	logic [17:0] overuse_limit_q, max_adapt_q;
	logic [7:0]  count_cap_q;
	logic [9:0]  max_step_q;

	// detector state
	logic [THR_W-1:0]           thr_q;
	logic [31:0]                ot_q;
	logic                       ot_valid_q;
	logic [15:0]                hits_q;
	logic signed [OFFSET_W-1:0] last_offset_q;
	logic [NOW_W-1:0]           last_ms_q;
	logic                       last_valid_q;
	logic [USAGE_W-1:0]         cur_state_q;

	// item being worked on
	logic signed [OFFSET_W-1:0] offset_q;
	logic [GTD_W-1:0]           gtd_q;
	logic [COUNT_W-1:0]         count_q;
	logic [NOW_W-1:0]           now_q;
	logic                       few_q;
	logic [THR_W-1:0]           mag_q;
	logic                       neg_q;
	logic [15:0]                k_q;
	logic [9:0]                 dt_q;

	seq_state_t state_q;

	logic                  m_tvalid_q;
	logic [USAGE_W-1:0]    m_usage_q;
	logic [THR_OUT_W-1:0]  m_thr_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	dod_mul_unit u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	logic        s_xfer, out_free;
	logic [7:0]  cap_cnt;
	logic [19:0] offset_mag;

	assign s_tready = state_q == ST_IDLE;
	assign s_xfer   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, m_thr_q, m_usage_q};

	assign cap_cnt    = (count_q > COUNT_W'(count_cap_q)) ? count_cap_q : count_q[7:0];
	assign offset_mag = offset_q[OFFSET_W-1] ? 20'(-offset_q) : 20'(offset_q);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_T: begin
				mul_a = MUL_A_W'(offset_mag);
				mul_b = MUL_B_W'(cap_cnt);
			end
			ST_MUL_K: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = k_q;
			end
			ST_MUL_DT: begin
				mul_a = mul_p[MUL_A_W-1:0];
				mul_b = MUL_B_W'(dt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// compare stage: |T| in Q16, classification and adaptation setup
	logic [34:0] abs_t;
	logic [34:0] thr_ext;
	logic        t_over, t_under, freeze, below;
	logic [31:0] ot_sum, ot_next;
	logic [15:0] hits_next;
	logic        alarm;
	logic [NOW_W-1:0] ref_ms, elapsed;
	logic [34:0] diff_abs;

	always_comb begin
		abs_t     = {mul_p[26:0], 8'd0};
		thr_ext   = 35'(thr_q);
		t_over    = !offset_q[OFFSET_W-1] && (abs_t > thr_ext);
		t_under   = offset_q[OFFSET_W-1] && (abs_t > thr_ext);
		freeze    = abs_t > (thr_ext + 35'({max_adapt_q, 8'd0}));
		below     = abs_t < thr_ext;
		diff_abs  = below ? (thr_ext - abs_t) : (abs_t - thr_ext);
		ot_sum    = ot_q + 32'(gtd_q);
		if (!ot_valid_q)
			ot_next = 32'(gtd_q >> 1);
		else if (ot_q > (32'hFFFF_FFFF - 32'(gtd_q)))
			ot_next = 32'hFFFF_FFFF;
		else
			ot_next = ot_sum;
		hits_next = (hits_q != 16'hFFFF) ? hits_q + 16'd1 : hits_q;
		alarm     = (ot_next > 32'(overuse_limit_q)) && (hits_next > 16'd1) &&
		            (offset_q >= last_offset_q);
		ref_ms    = last_valid_q ? last_ms_q : now_q;
		elapsed   = now_q - ref_ms;
	end

	// threshold update from the rounded step
	logic [36:0]        step;
	logic signed [39:0] thr_cand;

	always_comb begin
		step     = 37'((mul_p[52:0] + 53'h8000) >> 16);
		thr_cand = neg_q ? ($signed({14'd0, thr_q}) - $signed({3'd0, step}))
		                 : ($signed({14'd0, thr_q}) + $signed({3'd0, step}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_up_q       <= 16'd1226;
			gain_down_q     <= 16'd2556;
			overuse_limit_q <= 18'd5120;
			max_adapt_q     <= 18'd3840;
			count_cap_q     <= 8'd60;
			max_step_q      <= 10'd100;
			thr_q           <= THR_W'(3200 << 8);
			ot_q            <= '0;
			ot_valid_q      <= 1'b0;
			hits_q          <= '0;
			last_offset_q   <= '0;
			last_ms_q       <= '0;
			last_valid_q    <= 1'b0;
			cur_state_q     <= USAGE_NORMAL;
			state_q         <= ST_IDLE;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_UP:       gain_up_q       <= cfg_data[15:0];
					REG_GAIN_DOWN:     gain_down_q     <= cfg_data[15:0];
					REG_OVERUSE_LIMIT: overuse_limit_q <= cfg_data;
					REG_INIT_THR: begin
						thr_q <= thr_clamp(40'({cfg_data, 8'd0}));
					end
					REG_MAX_ADAPT:     max_adapt_q     <= cfg_data;
					REG_COUNT_CAP:     count_cap_q     <= cfg_data[7:0];
					REG_MAX_STEP:      max_step_q      <= cfg_data[9:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer)
						state_q <= ST_MUL_T;
				end
				ST_MUL_T: begin
					state_q <= few_q ? ST_DONE : ST_CMP;
				end
				ST_CMP: begin
					if (t_over) begin
						if (alarm) begin
							ot_q        <= '0;
							hits_q      <= '0;
							cur_state_q <= USAGE_OVER;
						end else begin
							ot_q   <= ot_next;
							hits_q <= hits_next;
						end
						ot_valid_q <= 1'b1;
					end else begin
						ot_q        <= '0;
						ot_valid_q  <= 1'b0;
						hits_q      <= '0;
						cur_state_q <= t_under ? USAGE_UNDER : USAGE_NORMAL;
					end
					last_offset_q <= offset_q;
					if (freeze) begin
						last_ms_q    <= now_q;
						last_valid_q <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_MUL_K;
					end
				end
				ST_MUL_K:  state_q <= ST_MUL_DT;
				ST_MUL_DT: state_q <= ST_UPD;
				ST_UPD: begin
					thr_q        <= thr_clamp(thr_cand);
					last_ms_q    <= now_q;
					last_valid_q <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			offset_q <= s_tdata[19:0];
			gtd_q    <= s_tdata[37:20];
			count_q  <= s_tdata[53:38];
			now_q    <= s_tdata[85:54];
			few_q    <= s_tdata[53:38] < 16'd2;
		end
		if (state_q == ST_CMP) begin
			mag_q <= diff_abs[THR_W-1:0];
			neg_q <= below;
			k_q   <= below ? gain_down_q : gain_up_q;
			dt_q  <= (elapsed > 32'(max_step_q)) ? max_step_q : elapsed[9:0];
		end
		if (state_q == ST_DONE && out_free) begin
			m_usage_q <= few_q ? USAGE_NORMAL : cur_state_q;
			m_thr_q   <= thr_q[THR_W-1:8];
		end
	end

	`DOD_ASSERT_ALWAYS(a_thr_range, clk, arst_n, (thr_q >= THR_MIN_Q16) && (thr_q <= THR_MAX_Q16), "threshold out of range")
	`DOD_ASSERT_ALWAYS(a_ot_clear, clk, arst_n, ot_valid_q || ((ot_q == '0) && (hits_q == '0)), "overuse accumulators not clear")
	`DOD_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, s_xfer, !s_tready, "accepted while busy")

endmodule

`default_nettype wire

// ----- hw/rtl/dod_mul_unit.sv -----
// Shared unsigned multiplier with registered product.
`default_nettype none

module dod_mul_unit (
	input  wire logic                        clk,
	input  wire logic [dod_pkg::MUL_A_W-1:0] a,
	input  wire logic [dod_pkg::MUL_B_W-1:0] b,
	output logic      [dod_pkg::MUL_P_W-1:0] p_q
);
	import dod_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire
